// ===== hw/rtl/bnfpa_pkg.sv =====
// Shared constants, codes and types of the next-fit page allocator.
package bnfpa_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int CNT_W     = PAGE_W + 1;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    localparam logic [1:0] CFG_PAGE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_RES_FIRST  = 2'd1;
    localparam logic [1:0] CFG_RES_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        OP_RELEASE,
        OP_ALLOC,
        OP_FREE,
        OP_QUERY
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_BAD_ARG,
        ST_NO_SPACE,
        ST_NOT_FREEABLE
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_EVAL,
        S_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic used_en;
        logic used_val;
        logic mgd_en;
        logic mgd_val;
    } map_wr_t;

endpackage

// ===== hw/rtl/bnfpa_map.sv =====
// Used and managed page bit maps with the clearing sweep after reset.
module bnfpa_map (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [bnfpa_pkg::PAGE_W-1:0] addr,
    input  bnfpa_pkg::map_wr_t           wr,
    output logic                         rd_used,
    output logic                         rd_mgd,
    output logic                         busy
);

    logic used_mem [bnfpa_pkg::NUM_PAGES];
    logic mgd_mem  [bnfpa_pkg::NUM_PAGES];
    logic [bnfpa_pkg::PAGE_W:0] clr_reg;
    logic rd_used_reg;
    logic rd_mgd_reg;

    assign busy    = ~clr_reg[bnfpa_pkg::PAGE_W];
    assign rd_used = rd_used_reg;
    assign rd_mgd  = rd_mgd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (busy)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            used_mem[clr_reg[bnfpa_pkg::PAGE_W-1:0]] <= 1'b1;
            mgd_mem[clr_reg[bnfpa_pkg::PAGE_W-1:0]]  <= 1'b0;
        end
        else
        begin
            if (wr.used_en)
            begin
                used_mem[addr] <= wr.used_val;
            end
            if (wr.mgd_en)
            begin
                mgd_mem[addr] <= wr.mgd_val;
            end
        end
        rd_used_reg <= used_mem[addr];
        rd_mgd_reg  <= mgd_mem[addr];
    end

endmodule

// ===== hw/rtl/bitmap_next_fit_page_allocator.sv =====
// Top level of the bitmap next-fit page allocator.
// Each page of a release, free check or allocation scan is read, then evaluated (S_RD, S_EVAL);
// marking or clearing a run writes its pages in turn in S_WR.
// Only one beat is in flight at a time: a new beat is taken only in S_IDLE.
// Reset: a sweep over all 4096 pages sets every page used and unmanaged; no beat is taken meanwhile.
module bitmap_next_fit_page_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   operation,
    input  logic [bnfpa_pkg::PAGE_W-1:0] page_index,
    input  logic [bnfpa_pkg::CNT_W-1:0]  page_count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   status,
    output logic [bnfpa_pkg::PAGE_W-1:0] alloc_start,
    output logic                         is_used,
    output logic [bnfpa_pkg::CNT_W-1:0]  free_count,
    output logic [bnfpa_pkg::CNT_W-1:0]  managed_count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [1:0]                   cfg_index,
    input  logic [bnfpa_pkg::CNT_W-1:0]  cfg_data
);

    localparam int PW = bnfpa_pkg::PAGE_W;
    localparam int CW = bnfpa_pkg::CNT_W;

    bnfpa_pkg::state_t  state_reg, state_next;
    bnfpa_pkg::op_t     op_reg, op_next;
    bnfpa_pkg::status_t res_status_reg, res_status_next;
    bnfpa_pkg::map_wr_t wr;

    logic [CW-1:0] limit_reg;
    logic [PW-1:0] res_first_reg;
    logic [CW-1:0] res_count_reg;

    logic [PW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] p_reg, p_next;
    logic [CW:0]   end_reg, end_next;
    logic          pass_reg, pass_next;
    logic [CW-1:0] run_len_reg, run_len_next;
    logic [PW-1:0] rs_reg, rs_next;
    logic [CW-1:0] ft_reg, ft_next;
    logic [CW-1:0] mt_reg, mt_next;
    logic [PW-1:0] sp_reg, sp_next;
    logic          res_used_reg, res_used_next;
    logic [PW-1:0] res_start_reg, res_start_next;

    logic          out_valid_reg;
    logic [1:0]    out_status_reg;
    logic [PW-1:0] out_start_reg;
    logic          out_used_reg;
    logic [CW-1:0] out_ft_reg;
    logic [CW-1:0] out_mt_reg;

    logic          rd_used, rd_mgd, busy;
    logic          in_fire, out_load;
    logic [CW-1:0] lim;
    logic [CW-1:0] idx_ext;
    logic [CW:0]   idx_plus_cnt;
    logic [CW:0]   res_end;
    logic          p_is_res;
    logic          dec_fail;
    bnfpa_pkg::status_t dec_status;
    logic          rd_end;
    logic          alloc_found;
    logic          free_fail;
    logic [PW-1:0] rs_eff;
    logic [CW:0]   rs_plus_cnt;
    logic [CW:0]   ft_plus_cnt;
    logic [CW-1:0] sp_ext;

    bnfpa_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .addr    (p_reg[PW-1:0]),
        .wr      (wr),
        .rd_used (rd_used),
        .rd_mgd  (rd_mgd),
        .busy    (busy)
    );

    assign in_ready  = (state_reg == bnfpa_pkg::S_IDLE) && !busy;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == bnfpa_pkg::S_DONE) && (!out_valid_reg || out_ready);

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign alloc_start   = out_start_reg;
    assign is_used       = out_used_reg;
    assign free_count    = out_ft_reg;
    assign managed_count = out_mt_reg;

    assign lim = (limit_reg > CW'(bnfpa_pkg::NUM_PAGES)) ? CW'(bnfpa_pkg::NUM_PAGES) : limit_reg;
    assign idx_ext      = {1'b0, idx_reg};
    assign idx_plus_cnt = {2'b00, idx_reg} + {1'b0, cnt_reg};
    assign res_end      = {2'b00, res_first_reg} + {1'b0, res_count_reg};
    assign p_is_res     = (p_reg >= {1'b0, res_first_reg}) && ({1'b0, p_reg} < res_end);
    assign rd_end       = {1'b0, p_reg} >= end_reg;
    assign rs_eff       = (run_len_reg == '0) ? p_reg[PW-1:0] : rs_reg;
    assign rs_plus_cnt  = {2'b00, rs_eff} + {1'b0, cnt_reg};
    assign ft_plus_cnt  = {1'b0, ft_reg} + {1'b0, cnt_reg};
    assign sp_ext       = {1'b0, sp_reg};
    assign alloc_found  = !rd_used && (({1'b0, run_len_reg} + 1'b1) == {1'b0, cnt_reg});
    assign free_fail    = (p_reg == '0) || !rd_mgd || p_is_res || !rd_used;

    always_comb
    begin
        dec_fail   = 1'b0;
        dec_status = bnfpa_pkg::ST_BAD_ARG;
        case (op_reg)
            bnfpa_pkg::OP_RELEASE:
            begin
                dec_fail = (cnt_reg == '0) || (idx_ext >= lim);
            end
            bnfpa_pkg::OP_ALLOC:
            begin
                if (cnt_reg == '0)
                begin
                    dec_fail = 1'b1;
                end
                else if (cnt_reg > ft_reg)
                begin
                    dec_fail   = 1'b1;
                    dec_status = bnfpa_pkg::ST_NO_SPACE;
                end
            end
            bnfpa_pkg::OP_FREE:
            begin
                dec_fail = (cnt_reg == '0) || (idx_ext >= lim) || (idx_plus_cnt > {1'b0, lim});
            end
            default:
            begin
                dec_fail = idx_ext >= lim;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bnfpa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = bnfpa_pkg::S_DECODE;
                end
            end
            bnfpa_pkg::S_DECODE:
            begin
                state_next = dec_fail ? bnfpa_pkg::S_DONE : bnfpa_pkg::S_RD;
            end
            bnfpa_pkg::S_RD:
            begin
                if (!rd_end)
                begin
                    state_next = bnfpa_pkg::S_EVAL;
                end
                else
                begin
                    case (op_reg)
                        bnfpa_pkg::OP_ALLOC: state_next = pass_reg ? bnfpa_pkg::S_DONE
                                                                   : bnfpa_pkg::S_RD;
                        bnfpa_pkg::OP_FREE:  state_next = bnfpa_pkg::S_WR;
                        default:             state_next = bnfpa_pkg::S_DONE;
                    endcase
                end
            end
            bnfpa_pkg::S_EVAL:
            begin
                case (op_reg)
                    bnfpa_pkg::OP_QUERY: state_next = bnfpa_pkg::S_DONE;
                    bnfpa_pkg::OP_FREE:  state_next = free_fail ? bnfpa_pkg::S_DONE
                                                                : bnfpa_pkg::S_RD;
                    bnfpa_pkg::OP_ALLOC: state_next = alloc_found ? bnfpa_pkg::S_WR
                                                                  : bnfpa_pkg::S_RD;
                    default:             state_next = bnfpa_pkg::S_RD;
                endcase
            end
            bnfpa_pkg::S_WR:
            begin
                if (rd_end)
                begin
                    state_next = bnfpa_pkg::S_DONE;
                end
            end
            bnfpa_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = bnfpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bnfpa_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next         = op_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        p_next          = p_reg;
        end_next        = end_reg;
        pass_next       = pass_reg;
        run_len_next    = run_len_reg;
        rs_next         = rs_reg;
        ft_next         = ft_reg;
        mt_next         = mt_reg;
        sp_next         = sp_reg;
        res_status_next = res_status_reg;
        res_used_next   = res_used_reg;
        res_start_next  = res_start_reg;
        wr              = '0;
        case (state_reg)
            bnfpa_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    op_next         = bnfpa_pkg::op_t'(operation);
                    idx_next        = page_index;
                    cnt_next        = page_count;
                    res_status_next = bnfpa_pkg::ST_OK;
                    res_used_next   = 1'b0;
                    res_start_next  = '0;
                end
            end
            bnfpa_pkg::S_DECODE:
            begin
                if (dec_fail)
                begin
                    res_status_next = dec_status;
                    res_used_next   = (op_reg == bnfpa_pkg::OP_QUERY);
                end
                else
                begin
                    pass_next    = 1'b0;
                    run_len_next = '0;
                    case (op_reg)
                        bnfpa_pkg::OP_RELEASE:
                        begin
                            p_next   = idx_ext;
                            end_next = (idx_plus_cnt > {1'b0, lim}) ? {1'b0, lim} : idx_plus_cnt;
                        end
                        bnfpa_pkg::OP_ALLOC:
                        begin
                            p_next   = sp_ext;
                            end_next = {1'b0, lim};
                        end
                        bnfpa_pkg::OP_FREE:
                        begin
                            p_next   = idx_ext;
                            end_next = idx_plus_cnt;
                        end
                        default:
                        begin
                            p_next   = idx_ext;
                            end_next = {1'b0, idx_ext} + 1'b1;
                        end
                    endcase
                end
            end
            bnfpa_pkg::S_RD:
            begin
                if (rd_end)
                begin
                    case (op_reg)
                        bnfpa_pkg::OP_ALLOC:
                        begin
                            if (pass_reg)
                            begin
                                res_status_next = bnfpa_pkg::ST_NO_SPACE;
                            end
                            else
                            begin
                                pass_next    = 1'b1;
                                p_next       = CW'(1);
                                end_next     = (sp_ext < lim) ? {1'b0, sp_ext} : {1'b0, lim};
                                run_len_next = '0;
                            end
                        end
                        bnfpa_pkg::OP_FREE:
                        begin
                            p_next = idx_ext;
                        end
                        default:
                        begin
                            res_status_next = bnfpa_pkg::ST_OK;
                        end
                    endcase
                end
            end
            bnfpa_pkg::S_EVAL:
            begin
                p_next = p_reg + 1'b1;
                case (op_reg)
                    bnfpa_pkg::OP_RELEASE:
                    begin
                        if (!rd_mgd)
                        begin
                            wr.mgd_en  = 1'b1;
                            wr.mgd_val = 1'b1;
                            mt_next    = (mt_reg == bnfpa_pkg::COUNT_MAX) ? mt_reg : mt_reg + 1'b1;
                            if ((p_reg != '0) && !p_is_res)
                            begin
                                wr.used_en  = 1'b1;
                                wr.used_val = 1'b0;
                                ft_next     = (ft_reg == bnfpa_pkg::COUNT_MAX) ? ft_reg
                                                                               : ft_reg + 1'b1;
                            end
                        end
                    end
                    bnfpa_pkg::OP_ALLOC:
                    begin
                        if (rd_used)
                        begin
                            run_len_next = '0;
                        end
                        else if (alloc_found)
                        begin
                            rs_next  = rs_eff;
                            p_next   = {1'b0, rs_eff};
                            end_next = rs_plus_cnt;
                        end
                        else
                        begin
                            rs_next      = rs_eff;
                            run_len_next = run_len_reg + 1'b1;
                        end
                    end
                    bnfpa_pkg::OP_FREE:
                    begin
                        if (free_fail)
                        begin
                            res_status_next = bnfpa_pkg::ST_NOT_FREEABLE;
                        end
                    end
                    default:
                    begin
                        res_status_next = bnfpa_pkg::ST_OK;
                        res_used_next   = rd_used;
                    end
                endcase
            end
            bnfpa_pkg::S_WR:
            begin
                if (!rd_end)
                begin
                    wr.used_en  = 1'b1;
                    wr.used_val = (op_reg == bnfpa_pkg::OP_ALLOC);
                    p_next      = p_reg + 1'b1;
                end
                else if (op_reg == bnfpa_pkg::OP_ALLOC)
                begin
                    ft_next         = ft_reg - cnt_reg;
                    sp_next         = (end_reg >= {1'b0, lim}) ? PW'(1) : end_reg[PW-1:0];
                    res_status_next = bnfpa_pkg::ST_OK;
                    res_start_next  = rs_reg;
                end
                else
                begin
                    ft_next = (ft_plus_cnt > {1'b0, bnfpa_pkg::COUNT_MAX}) ? bnfpa_pkg::COUNT_MAX
                                                                          : ft_plus_cnt[CW-1:0];
                    if (idx_reg < sp_reg)
                    begin
                        sp_next = idx_reg;
                    end
                    res_status_next = bnfpa_pkg::ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bnfpa_pkg::S_IDLE;
            ft_reg        <= '0;
            mt_reg        <= '0;
            sp_reg        <= PW'(1);
            limit_reg     <= CW'(bnfpa_pkg::NUM_PAGES);
            res_first_reg <= '0;
            res_count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ft_reg    <= ft_next;
            mt_reg    <= mt_next;
            sp_reg    <= sp_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bnfpa_pkg::CFG_PAGE_LIMIT: limit_reg     <= cfg_data;
                    bnfpa_pkg::CFG_RES_FIRST:  res_first_reg <= cfg_data[PW-1:0];
                    bnfpa_pkg::CFG_RES_COUNT:  res_count_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        cnt_reg        <= cnt_next;
        p_reg          <= p_next;
        end_reg        <= end_next;
        pass_reg       <= pass_next;
        run_len_reg    <= run_len_next;
        rs_reg         <= rs_next;
        res_status_reg <= res_status_next;
        res_used_reg   <= res_used_next;
        res_start_reg  <= res_start_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_start_reg  <= res_start_reg;
            out_used_reg   <= res_used_reg;
            out_ft_reg     <= ft_reg;
            out_mt_reg     <= mt_reg;
        end
    end

endmodule

// ===== verif/bitmap_next_fit_page_allocator_tb.sv =====
// Self-checking testbench of the next-fit page allocator: directed table, then random traffic.
module bitmap_next_fit_page_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PW = bnfpa_pkg::PAGE_W;
    localparam int CW = bnfpa_pkg::CNT_W;
    localparam int NP = bnfpa_pkg::NUM_PAGES;

    typedef struct {
        bnfpa_pkg::status_t status;
        logic [PW-1:0]      alloc_start;
        logic               is_used;
        logic [CW-1:0]      free_count;
        logic [CW-1:0]      managed_count;
    } alloc_result_t;

    typedef struct {
        bnfpa_pkg::op_t     op;
        int                 index;
        int                 count;
        bit                 typed;
        alloc_result_t      res;
    } table_row_t;

    typedef struct {
        int first;
        int len;
    } page_run_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         operation;
    logic [PW-1:0]      page_index;
    logic [CW-1:0]      page_count;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         status;
    logic [PW-1:0]      alloc_start;
    logic               is_used;
    logic [CW-1:0]      free_count;
    logic [CW-1:0]      managed_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [CW-1:0]      cfg_data;

    bit                 page_used [NP];
    bit                 page_managed [NP];
    int                 free_cnt;
    int                 managed_cnt;
    int                 next_fit_ptr;
    int                 limit_reg;
    int                 res_first;
    int                 res_len;

    alloc_result_t      pending_results[$];
    page_run_t          live_runs[$];
    int                 errors;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 items_sent;

    bitmap_next_fit_page_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .page_index    (page_index),
        .page_count    (page_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .alloc_start   (alloc_start),
        .is_used       (is_used),
        .free_count    (free_count),
        .managed_count (managed_count),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #500_000_000;
        $display("bitmap_next_fit_page_allocator regression: fail");
        $finish;
    end

    function automatic bit page_reserved(int p);
        return p >= res_first && p < res_first + res_len;
    endfunction

    function automatic int sat_add(int v, int d);
        return (v + d > 8191) ? 8191 : v + d;
    endfunction

    function automatic alloc_result_t allocator_step(bnfpa_pkg::op_t op, int idx, int cnt);
        alloc_result_t r;
        int lim;
        int stop;
        int begin_p;
        int end_p;
        int run_len;
        int run_first;
        bit found;
        bit bad;
        page_run_t run;
        lim = (limit_reg < NP) ? limit_reg : NP;
        r.status = bnfpa_pkg::ST_OK;
        r.alloc_start = '0;
        r.is_used = 1'b0;
        case (op)
            bnfpa_pkg::OP_RELEASE:
            begin
                if (cnt == 0 || idx >= lim)
                begin
                    r.status = bnfpa_pkg::ST_BAD_ARG;
                end
                else
                begin
                    stop = (idx + cnt > lim) ? lim : idx + cnt;
                    for (int p = idx; p < stop; p++)
                    begin
                        if (!page_managed[p])
                        begin
                            page_managed[p] = 1'b1;
                            managed_cnt = sat_add(managed_cnt, 1);
                            if (p != 0 && !page_reserved(p))
                            begin
                                page_used[p] = 1'b0;
                                free_cnt = sat_add(free_cnt, 1);
                            end
                        end
                    end
                end
            end
            bnfpa_pkg::OP_ALLOC:
            begin
                found = 1'b0;
                if (cnt == 0)
                begin
                    r.status = bnfpa_pkg::ST_BAD_ARG;
                end
                else if (cnt > free_cnt)
                begin
                    r.status = bnfpa_pkg::ST_NO_SPACE;
                end
                else
                begin
                    for (int pass = 0; pass < 2 && !found; pass++)
                    begin
                        begin_p = (pass == 0) ? next_fit_ptr : 1;
                        end_p = (pass == 0) ? lim : ((next_fit_ptr < lim) ? next_fit_ptr : lim);
                        run_len = 0;
                        run_first = 0;
                        for (int p = begin_p; p < end_p && !found; p++)
                        begin
                            if (page_used[p])
                            begin
                                run_len = 0;
                            end
                            else
                            begin
                                if (run_len == 0)
                                    run_first = p;
                                run_len++;
                                if (run_len == cnt)
                                    found = 1'b1;
                            end
                        end
                    end
                    if (found)
                    begin
                        for (int q = run_first; q < run_first + cnt; q++)
                            page_used[q] = 1'b1;
                        free_cnt -= cnt;
                        next_fit_ptr = run_first + cnt;
                        if (next_fit_ptr >= lim)
                            next_fit_ptr = 1;
                        r.alloc_start = PW'(run_first);
                        run.first = run_first;
                        run.len = cnt;
                        live_runs.push_back(run);
                    end
                    else
                    begin
                        r.status = bnfpa_pkg::ST_NO_SPACE;
                    end
                end
            end
            bnfpa_pkg::OP_FREE:
            begin
                bad = 1'b0;
                if (cnt == 0 || idx >= lim || cnt > lim - idx)
                begin
                    r.status = bnfpa_pkg::ST_BAD_ARG;
                end
                else
                begin
                    for (int p = idx; p < idx + cnt; p++)
                        if (p == 0 || !page_managed[p] || page_reserved(p) || !page_used[p])
                            bad = 1'b1;
                    if (bad)
                    begin
                        r.status = bnfpa_pkg::ST_NOT_FREEABLE;
                    end
                    else
                    begin
                        for (int p = idx; p < idx + cnt; p++)
                            page_used[p] = 1'b0;
                        free_cnt = sat_add(free_cnt, cnt);
                        if (idx < next_fit_ptr)
                            next_fit_ptr = idx;
                    end
                end
            end
            default:
            begin
                if (idx >= lim)
                begin
                    r.status = bnfpa_pkg::ST_BAD_ARG;
                    r.is_used = 1'b1;
                end
                else
                begin
                    r.is_used = page_used[idx];
                end
            end
        endcase
        r.free_count = CW'(free_cnt);
        r.managed_count = CW'(managed_cnt);
        return r;
    endfunction

    task automatic send_request(bnfpa_pkg::op_t op, int idx, int cnt, bit typed,
                                alloc_result_t want);
        alloc_result_t got;
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        operation = op;
        page_index = idx[PW-1:0];
        page_count = cnt[CW-1:0];
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        got = allocator_step(op, idx, cnt);
        pending_results.push_back(typed ? want : got);
        items_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_register(logic [1:0] idx, int value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value[CW-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            bnfpa_pkg::CFG_PAGE_LIMIT: limit_reg = value;
            bnfpa_pkg::CFG_RES_FIRST:  res_first = value;
            default:                   res_len = value;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, got status %0d",
                         $time, status);
            end
            else
            begin
                e = pending_results.pop_front();
                compare_field("status", 32'(e.status), 32'(status));
                compare_field("alloc_start", 32'(e.alloc_start), 32'(alloc_start));
                compare_field("is_used", 32'(e.is_used), 32'(is_used));
                compare_field("free_count", 32'(e.free_count), 32'(free_count));
                compare_field("managed_count", 32'(e.managed_count), 32'(managed_count));
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    function automatic alloc_result_t res(bnfpa_pkg::status_t s, int st, bit u, int f, int m);
        alloc_result_t r;
        r.status = s;
        r.alloc_start = PW'(st);
        r.is_used = u;
        r.free_count = CW'(f);
        r.managed_count = CW'(m);
        return r;
    endfunction

    initial
    begin
        table_row_t         dir_table[$];
        alloc_result_t      none;
        int                 lim;
        int                 roll;
        int                 idx;
        int                 idx_hi;
        int                 cnt;
        int                 pick;
        bnfpa_pkg::op_t     op;
        int                 limits[9]  = '{200, 64, 1, 0, 8191, 300, 128, 40, 4096};
        int                 firsts[9]  = '{50, 0, 0, 3, 4095, 10, 100, 4095, 0};
        int                 lens[9]    = '{20, 4096, 0, 5, 1, 8191, 0, 8191, 0};
        int                 n_items[9] = '{90, 90, 40, 40, 70, 90, 130, 90, 35};

        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = bnfpa_pkg::OP_RELEASE;
        page_index = '0;
        page_count = '0;
        cfg_valid = 1'b0;
        cfg_index = bnfpa_pkg::CFG_PAGE_LIMIT;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        send_idle_pct = 17;
        recv_idle_pct = 88;
        for (int p = 0; p < NP; p++)
        begin
            page_used[p] = 1'b1;
            page_managed[p] = 1'b0;
        end
        free_cnt = 0;
        managed_cnt = 0;
        next_fit_ptr = 1;
        limit_reg = 4096;
        res_first = 0;
        res_len = 0;
        none = res(bnfpa_pkg::ST_OK, 0, 0, 0, 0);

        dir_table = '{
            '{bnfpa_pkg::OP_QUERY,   0,    0,    1, res(bnfpa_pkg::ST_OK, 0, 1, 0, 0)},
            '{bnfpa_pkg::OP_ALLOC,   0,    1,    1, res(bnfpa_pkg::ST_NO_SPACE, 0, 0, 0, 0)},
            '{bnfpa_pkg::OP_RELEASE, 0,    0,    1, res(bnfpa_pkg::ST_BAD_ARG, 0, 0, 0, 0)},
            '{bnfpa_pkg::OP_FREE,    5,    1,    1,
              res(bnfpa_pkg::ST_NOT_FREEABLE, 0, 0, 0, 0)},
            '{bnfpa_pkg::OP_QUERY,   4095, 0,    1, res(bnfpa_pkg::ST_OK, 0, 1, 0, 0)},
            '{bnfpa_pkg::OP_RELEASE, 0,    16,   1, res(bnfpa_pkg::ST_OK, 0, 0, 15, 16)},
            '{bnfpa_pkg::OP_QUERY,   0,    0,    1, res(bnfpa_pkg::ST_OK, 0, 1, 15, 16)},
            '{bnfpa_pkg::OP_QUERY,   1,    0,    1, res(bnfpa_pkg::ST_OK, 0, 0, 15, 16)},
            '{bnfpa_pkg::OP_ALLOC,   0,    4,    1, res(bnfpa_pkg::ST_OK, 1, 0, 11, 16)},
            '{bnfpa_pkg::OP_ALLOC,   0,    0,    1, res(bnfpa_pkg::ST_BAD_ARG, 0, 0, 11, 16)},
            '{bnfpa_pkg::OP_ALLOC,   0,    12,   1, res(bnfpa_pkg::ST_NO_SPACE, 0, 0, 11, 16)},
            '{bnfpa_pkg::OP_ALLOC,   0,    11,   1, res(bnfpa_pkg::ST_OK, 5, 0, 0, 16)},
            '{bnfpa_pkg::OP_FREE,    0,    1,    1,
              res(bnfpa_pkg::ST_NOT_FREEABLE, 0, 0, 0, 16)},
            '{bnfpa_pkg::OP_FREE,    1,    4,    1, res(bnfpa_pkg::ST_OK, 0, 0, 4, 16)},
            '{bnfpa_pkg::OP_FREE,    1,    4,    1,
              res(bnfpa_pkg::ST_NOT_FREEABLE, 0, 0, 4, 16)},
            '{bnfpa_pkg::OP_FREE,    4095, 2,    1, res(bnfpa_pkg::ST_BAD_ARG, 0, 0, 4, 16)},
            '{bnfpa_pkg::OP_FREE,    0,    0,    1, res(bnfpa_pkg::ST_BAD_ARG, 0, 0, 4, 16)},
            '{bnfpa_pkg::OP_RELEASE, 4095, 4096, 1, res(bnfpa_pkg::ST_OK, 0, 0, 5, 17)},
            '{bnfpa_pkg::OP_RELEASE, 4000, 8191, 1, res(bnfpa_pkg::ST_OK, 0, 0, 100, 112)},
            '{bnfpa_pkg::OP_ALLOC,   0,    4096, 1,
              res(bnfpa_pkg::ST_NO_SPACE, 0, 0, 100, 112)},
            '{bnfpa_pkg::OP_ALLOC,   0,    8191, 1,
              res(bnfpa_pkg::ST_NO_SPACE, 0, 0, 100, 112)},
            '{bnfpa_pkg::OP_ALLOC,   0,    3,    0, none},
            '{bnfpa_pkg::OP_ALLOC,   0,    90,   0, none},
            '{bnfpa_pkg::OP_FREE,    4000, 96,   0, none},
            '{bnfpa_pkg::OP_QUERY,   4050, 0,    0, none}
        };

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_table[i])
            send_request(dir_table[i].op, dir_table[i].index, dir_table[i].count,
                         dir_table[i].typed, dir_table[i].res);

        for (int ph = 0; ph < 9; ph++)
        begin
            drain();
            write_register(bnfpa_pkg::CFG_PAGE_LIMIT, limits[ph]);
            write_register(bnfpa_pkg::CFG_RES_FIRST, firsts[ph]);
            write_register(bnfpa_pkg::CFG_RES_COUNT, lens[ph]);
            lim = (limit_reg < NP) ? limit_reg : NP;
            live_runs.delete();
            for (int n = 0; n < n_items[ph]; n++)
            begin
                if (items_sent > 500)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                else if (items_sent > 260)
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 17;
                end
                if (ph == 1 && n == 45)
                begin
                    while (pending_results.size() != 0)
                        @(posedge clk);
                    @(negedge clk);
                end
                roll = $urandom_range(0, 99);
                idx_hi = (lim + 8 > 4095) ? 4095 : lim + 8;
                idx = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(0, idx_hi);
                cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 8191)
                                                   : $urandom_range(0, 16);
                if (roll < 20)
                begin
                    op = bnfpa_pkg::OP_RELEASE;
                end
                else if (roll < 55)
                begin
                    op = bnfpa_pkg::OP_ALLOC;
                    if (cnt > 64 && ph == 8)
                        cnt = 4096;
                end
                else if (roll < 85)
                begin
                    op = bnfpa_pkg::OP_FREE;
                    if (live_runs.size() != 0 && $urandom_range(0, 3) != 0)
                    begin
                        pick = $urandom_range(0, live_runs.size() - 1);
                        idx = live_runs[pick].first;
                        cnt = live_runs[pick].len;
                        live_runs.delete(pick);
                    end
                end
                else
                begin
                    op = bnfpa_pkg::OP_QUERY;
                end
                send_request(op, idx, cnt, 1'b0, none);
            end
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("bitmap_next_fit_page_allocator regression: pass");
        else
            $display("bitmap_next_fit_page_allocator regression: fail");
        $finish;
    end
endmodule
